/* rtl/hrlp_pkg.sv */
package hrlp_pkg;

  // one-hot parser phase
  typedef enum logic [7:0] {
    PH_IDLE   = 8'b0000_0001,
    PH_MFIRST = 8'b0000_0010,
    PH_PSEC   = 8'b0000_0100,
    PH_METHOD = 8'b0000_1000,
    PH_SP     = 8'b0001_0000,
    PH_URI    = 8'b0010_0000,
    PH_QUERY  = 8'b0100_0000,
    PH_VER    = 8'b1000_0000
  } phase_t;

  localparam logic [1:0] CLS_FRAME   = 2'd0;
  localparam logic [1:0] CLS_URI     = 2'd1;
  localparam logic [1:0] CLS_QUERY   = 2'd2;
  localparam logic [1:0] CLS_IGNORED = 2'd3;

  localparam logic [1:0] RES_OK         = 2'd0;
  localparam logic [1:0] RES_BAD_METHOD = 2'd1;
  localparam logic [1:0] RES_NO_URI     = 2'd2;
  localparam logic [1:0] RES_BAD_VER    = 2'd3;

  localparam logic [2:0] MTH_OPTIONS = 3'd0;
  localparam logic [2:0] MTH_GET     = 3'd1;
  localparam logic [2:0] MTH_HEAD    = 3'd2;
  localparam logic [2:0] MTH_POST    = 3'd3;
  localparam logic [2:0] MTH_PUT     = 3'd4;
  localparam logic [2:0] MTH_DELETE  = 3'd5;
  localparam logic [2:0] MTH_TRACE   = 3'd6;
  localparam logic [2:0] MTH_CONNECT = 3'd7;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_QMARK = 8'h3F;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;

  typedef struct packed {
    logic       line_start;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic [1:0] byte_class;
    logic [7:0] byte_echo;
    logic       line_done;
    logic [1:0] parse_result;
    logic [2:0] method_id;
    logic [3:0] ver_major;
    logic [3:0] ver_minor;
  } out_item_t;

  typedef struct packed {
    phase_t     phase;
    logic [2:0] cand;
    logic [2:0] mpos;
    logic       uri_ne;
    logic [3:0] vpos;
    logic [3:0] major;
    logic [3:0] minor;
  } ctx_t;

  function automatic logic [7:0] method_char(input logic [2:0] m, input logic [2:0] p);
    logic [55:0] name;
    case (m)
      MTH_OPTIONS: name = "OPTIONS";
      MTH_GET:     name = {"GET", 32'h0};
      MTH_HEAD:    name = {"HEAD", 24'h0};
      MTH_POST:    name = {"POST", 24'h0};
      MTH_PUT:     name = {"PUT", 32'h0};
      MTH_DELETE:  name = {"DELETE", 8'h0};
      MTH_TRACE:   name = {"TRACE", 16'h0};
      MTH_CONNECT: name = "CONNECT";
      default:     name = '0;
    endcase
    // character 0 sits in the top byte
    return name[6'(55 - 8 * int'(p)) -: 8];
  endfunction

  function automatic logic [2:0] method_len(input logic [2:0] m);
    case (m)
      MTH_OPTIONS: return 3'd7;
      MTH_GET:     return 3'd3;
      MTH_HEAD:    return 3'd4;
      MTH_POST:    return 3'd4;
      MTH_PUT:     return 3'd3;
      MTH_DELETE:  return 3'd6;
      MTH_TRACE:   return 3'd5;
      MTH_CONNECT: return 3'd7;
      default:     return 3'd7;
    endcase
  endfunction

endpackage

/* rtl/hrlp_in_if.sv */
interface hrlp_in_if;
  import hrlp_pkg::*;
  logic       valid;
  logic       ready;
  logic       line_start;
  logic [7:0] data_byte;

  modport source (output valid, output line_start, output data_byte, input ready);
  modport sink   (input valid, input line_start, input data_byte, output ready);
endinterface

/* rtl/hrlp_out_if.sv */
interface hrlp_out_if;
  import hrlp_pkg::*;
  logic       valid;
  logic       ready;
  logic [1:0] byte_class;
  logic [7:0] byte_echo;
  logic       line_done;
  logic [1:0] parse_result;
  logic [2:0] method_id;
  logic [3:0] ver_major;
  logic [3:0] ver_minor;

  modport source (output valid, output byte_class, output byte_echo, output line_done,
                  output parse_result, output method_id, output ver_major,
                  output ver_minor, input ready);
  modport sink   (input valid, input byte_class, input byte_echo, input line_done,
                  input parse_result, input method_id, input ver_major,
                  input ver_minor, output ready);
endinterface

/* rtl/hrlp_in_reg.sv */
module hrlp_in_reg
  import hrlp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  hrlp_in_if.sink     in_ch,
  output in_item_t    item,
  output logic        item_vld,
  input  logic        item_take
);

  in_item_t item_r;
  logic     vld_r, vld_nxt;

  assign in_ch.ready = !vld_r || item_take;
  assign vld_nxt     = in_ch.valid ? 1'b1 : (vld_r && !item_take);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (in_ch.ready) begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      item_r.line_start <= in_ch.line_start;
      item_r.data_byte  <= in_ch.data_byte;
    end
  end

  assign item     = item_r;
  assign item_vld = vld_r;

endmodule

/* rtl/hrlp_engine.sv */
module hrlp_engine
  import hrlp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  in_item_t    item,
  input  logic        item_vld,
  output logic        item_take,
  hrlp_out_if.source  out_ch
);

  ctx_t      ctx_r, ctx_nxt;
  ctx_t      wk;
  out_item_t res_r, res_nxt;
  logic      out_vld_r;

  logic [7:0] b, u;
  logic       done, hit, ok;
  logic [1:0] cls, code;
  logic [3:0] np;

  assign item_take = item_vld && (!out_vld_r || out_ch.ready);

  always_comb begin
    b   = item.data_byte;
    u   = (b >= "a" && b <= "z") ? b - 8'd32 : b;
    wk  = ctx_r;
    if (item.line_start) begin
      wk       = '0;
      wk.phase = PH_MFIRST;
    end
    ctx_nxt = wk;
    cls     = CLS_FRAME;
    done    = 1'b0;
    code    = RES_OK;
    hit     = 1'b1;
    ok      = 1'b0;
    np      = {1'b0, wk.mpos} + 4'd1;

    case (wk.phase)
      PH_MFIRST: begin
        case (u)
          "O":     ctx_nxt.cand = MTH_OPTIONS;
          "G":     ctx_nxt.cand = MTH_GET;
          "H":     ctx_nxt.cand = MTH_HEAD;
          "D":     ctx_nxt.cand = MTH_DELETE;
          "T":     ctx_nxt.cand = MTH_TRACE;
          "C":     ctx_nxt.cand = MTH_CONNECT;
          "P": begin
            ctx_nxt.phase = PH_PSEC;
            hit = 1'b0;
          end
          default: begin
            hit  = 1'b0;
            done = 1'b1;
            code = RES_BAD_METHOD;
          end
        endcase
        if (hit) begin
          ctx_nxt.mpos  = 3'd1;
          ctx_nxt.phase = PH_METHOD;
        end
      end
      PH_PSEC: begin
        if (u == "O" || u == "U") begin
          ctx_nxt.cand  = (u == "O") ? MTH_POST : MTH_PUT;
          ctx_nxt.mpos  = 3'd2;
          ctx_nxt.phase = PH_METHOD;
        end else begin
          done = 1'b1;
          code = RES_BAD_METHOD;
        end
      end
      PH_METHOD: begin
        if (u != method_char(wk.cand, wk.mpos)) begin
          done = 1'b1;
          code = RES_BAD_METHOD;
        end else begin
          ctx_nxt.mpos = np[2:0];
          if (np >= {1'b0, method_len(wk.cand)}) ctx_nxt.phase = PH_SP;
        end
      end
      PH_SP: begin
        if (b == CH_SP) begin
          ctx_nxt.uri_ne = 1'b0;
          ctx_nxt.phase  = PH_URI;
        end else begin
          done = 1'b1;
          code = RES_NO_URI;
        end
      end
      PH_URI: begin
        if (b == CH_SP || b == CH_QMARK || b == CH_NUL) begin
          if (!wk.uri_ne) begin
            done = 1'b1;
            code = RES_NO_URI;
          end else if (b == CH_QMARK) begin
            ctx_nxt.phase = PH_QUERY;
          end else if (b == CH_SP) begin
            ctx_nxt.vpos  = 4'd1;
            ctx_nxt.phase = PH_VER;
          end else begin
            done = 1'b1;
            code = RES_BAD_VER;
          end
        end else begin
          cls            = CLS_URI;
          ctx_nxt.uri_ne = 1'b1;
        end
      end
      PH_QUERY: begin
        if (b == CH_SP) begin
          ctx_nxt.vpos  = 4'd1;
          ctx_nxt.phase = PH_VER;
        end else if (b == CH_NUL) begin
          done = 1'b1;
          code = RES_BAD_VER;
        end else begin
          cls = CLS_QUERY;
        end
      end
      PH_VER: begin
        // position walks "HTTP/d.d\r\n"; digits carry their value in the low nibble
        case (wk.vpos)
          4'd1:    ok = (b == "H");
          4'd2:    ok = (b == "T");
          4'd3:    ok = (b == "T");
          4'd4:    ok = (b == "P");
          4'd5:    ok = (b == "/");
          4'd6:    ok = (b >= "0" && b <= "9");
          4'd7:    ok = (b == ".");
          4'd8:    ok = (b >= "0" && b <= "9");
          4'd9:    ok = (b == CH_CR);
          4'd10:   ok = (b == CH_LF);
          default: ok = 1'b0;
        endcase
        if (ok && wk.vpos == 4'd6) ctx_nxt.major = b[3:0];
        if (ok && wk.vpos == 4'd8) ctx_nxt.minor = b[3:0];
        if (!ok) begin
          done = 1'b1;
          code = RES_BAD_VER;
        end else if (wk.vpos == 4'd10) begin
          done = 1'b1;
        end else begin
          ctx_nxt.vpos = wk.vpos + 4'd1;
        end
      end
      default: cls = CLS_IGNORED;
    endcase

    if (done) ctx_nxt.phase = PH_IDLE;

    res_nxt.byte_class   = cls;
    res_nxt.byte_echo    = b;
    res_nxt.line_done    = done;
    res_nxt.parse_result = done ? code : RES_OK;
    res_nxt.method_id    = done ? ctx_nxt.cand : 3'd0;
    res_nxt.ver_major    = (done && code == RES_OK) ? ctx_nxt.major : 4'd0;
    res_nxt.ver_minor    = (done && code == RES_OK) ? ctx_nxt.minor : 4'd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctx_r     <= '{PH_IDLE, 3'd0, 3'd0, 1'b0, 4'd0, 4'd0, 4'd0};
      out_vld_r <= 1'b0;
    end else begin
      if (item_take) ctx_r <= ctx_nxt;
      if (item_take) out_vld_r <= 1'b1;
      else if (out_ch.ready) out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item_take) res_r <= res_nxt;
  end

  assign out_ch.valid        = out_vld_r;
  assign out_ch.byte_class   = res_r.byte_class;
  assign out_ch.byte_echo    = res_r.byte_echo;
  assign out_ch.line_done    = res_r.line_done;
  assign out_ch.parse_result = res_r.parse_result;
  assign out_ch.method_id    = res_r.method_id;
  assign out_ch.ver_major    = res_r.ver_major;
  assign out_ch.ver_minor    = res_r.ver_minor;

  a_done_goes_idle: assert property (@(posedge clk) disable iff (!rst_n)
    item_take && done |=> ctx_r.phase == PH_IDLE)
    else $error("parser not idle after line done");

  a_done_is_framing: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && res_r.line_done |-> res_r.byte_class == CLS_FRAME)
    else $error("done beat with non-framing class");

  a_err_no_version: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && res_r.parse_result != RES_OK |->
      res_r.line_done && res_r.ver_major == 4'd0 && res_r.ver_minor == 4'd0)
    else $error("error code without done or with version digits");

  a_start_not_ignored: assert property (@(posedge clk) disable iff (!rst_n)
    item_take && item.line_start |=> res_r.byte_class == CLS_FRAME)
    else $error("line start byte classed as ignored");

endmodule

/* rtl/http_request_line_parser_top.sv */
// HTTP request line parser.
// in_ch: one raw request-line byte per beat (valid/ready); line_start marks
//   the first method byte of a new line and restarts the parser.
// out_ch: exactly one result beat per input beat, in order: byte class
//   (framing, URI, query, ignored), the echoed byte, and on the last byte of
//   a line (final LF or first error) line_done with status, method code and
//   the HTTP major/minor digits.
// An input beat passes the input register, then the per-byte state update
//   and the result register, which are loaded in the same cycle.
// Throughput is one byte per cycle while out_ch takes results; the phase
//   register closes its loop through combinational compare logic.
// Reset (rst_n low, synchronous) empties both registers and leaves the
//   parser idle; bytes before the first line_start come out as ignored.
// When out_ch stalls the result register holds; the input register still
//   takes one more beat if it was empty, then in_ch.ready drops until the result is taken.
module http_request_line_parser_top
  import hrlp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  hrlp_in_if.sink     in_ch,
  hrlp_out_if.source  out_ch
);

  in_item_t item;
  logic     item_vld;
  logic     item_take;

  hrlp_in_reg u_in_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .item      (item),
    .item_vld  (item_vld),
    .item_take (item_take)
  );

  hrlp_engine u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .item      (item),
    .item_vld  (item_vld),
    .item_take (item_take),
    .out_ch    (out_ch)
  );

endmodule
